### hdl/vtpy_pkg.sv
package vtpy_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned SqW     = 2 * DiffW;
  localparam int unsigned RadW    = SqW + 2;
  localparam int unsigned RootW   = RadW / 2;
  localparam int unsigned CordW   = 64;
  localparam int unsigned AngW    = 32;
  localparam int unsigned PitchW  = 24;
  localparam int unsigned YawW    = 25;
  localparam int unsigned DistW   = 33;
  localparam int unsigned AtanLen = 32;

  localparam logic signed [AngW-1:0] HalfTurn   = 32'sd11796480;
  localparam logic signed [AngW-1:0] PitchLimit = 32'sd5832704;

  localparam logic [AngW-1:0] AtanDeg [AtanLen] = '{
    32'd2949120, 32'd1740967, 32'd919879, 32'd466945, 32'd234379, 32'd117304,
    32'd58666, 32'd29335, 32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917,
    32'd458, 32'd229, 32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2,
    32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dz;
    logic                    nz;
  } vec_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  z;
  } cordic_t;

  function automatic cordic_t cordic_init(logic signed [CordW-1:0] y,
                                          logic signed [CordW-1:0] x);
    cordic_t c;
    c.z = '0;
    c.x = x;
    c.y = y;
    if (x[CordW-1]) begin
      c.z = y[CordW-1] ? -HalfTurn : HalfTurn;
      c.x = -x;
      c.y = -y;
    end
    c.x = c.x <<< 16;
    c.y = c.y <<< 16;
    return c;
  endfunction

endpackage

### hdl/vtpy_front.sv
module vtpy_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [6*vtpy_pkg::CoordW-1:0] data_i,
  output logic                          valid_o,
  output vtpy_pkg::vec_t                vec_o,
  output logic [vtpy_pkg::RadW-1:0]     nh_o,
  output logic [vtpy_pkg::RadW-1:0]     nd_o
);

  localparam int unsigned CW = vtpy_pkg::CoordW;
  localparam int unsigned DW = vtpy_pkg::DiffW;
  localparam int unsigned SW = vtpy_pkg::SqW;
  localparam int unsigned RW = vtpy_pkg::RadW;

  logic [2:0] valid_q;

  logic signed [DW-1:0] d_d [3];
  logic [DW-1:0]        a_d [3];
  logic signed [DW-1:0] d1_q [3];
  logic [DW-1:0]        a1_q [3];
  vtpy_pkg::vec_t       v2_q, v3_q;
  logic [SW-1:0]        sq_q [3];
  logic [RW-1:0]        nh_q, nd_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_d[k] = $signed({data_i[(k+3)*CW+CW-1], data_i[(k+3)*CW +: CW]})
             - $signed({data_i[k*CW+CW-1], data_i[k*CW +: CW]});
      a_d[k] = d_d[k][DW-1] ? DW'($signed({data_i[k*CW+CW-1], data_i[k*CW +: CW]})
             - $signed({data_i[(k+3)*CW+CW-1], data_i[(k+3)*CW +: CW]}))
             : DW'(d_d[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        d1_q[k] <= d_d[k];
        a1_q[k] <= a_d[k];
        sq_q[k] <= SW'(a1_q[k]) * SW'(a1_q[k]);
      end
      v2_q.dx <= d1_q[0];
      v2_q.dy <= d1_q[1];
      v2_q.dz <= d1_q[2];
      v2_q.nz <= (d1_q[0] != '0) || (d1_q[1] != '0) || (d1_q[2] != '0);
      v3_q    <= v2_q;
      nh_q    <= RW'(sq_q[0]) + RW'(sq_q[1]);
      nd_q    <= RW'(sq_q[0]) + RW'(sq_q[1]) + RW'(sq_q[2]);
    end
  end

  assign valid_o = valid_q[2];
  assign vec_o   = v3_q;
  assign nh_o    = nh_q;
  assign nd_o    = nd_q;

endmodule

### hdl/vtpy_sqrt.sv
module vtpy_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  vtpy_pkg::vec_t                 vec_i,
  input  logic [vtpy_pkg::RadW-1:0]      nh_i,
  input  logic [vtpy_pkg::RadW-1:0]      nd_i,
  output logic                           valid_o,
  output vtpy_pkg::vec_t                 vec_o,
  output logic [vtpy_pkg::RootW-1:0]     horiz_o,
  output logic [vtpy_pkg::RootW-1:0]     dist_o
);

  localparam int unsigned RW = vtpy_pkg::RadW;
  localparam int unsigned QW = vtpy_pkg::RootW;

  logic           valid_q [QW+1];
  vtpy_pkg::vec_t vec_q   [QW+1];
  logic [RW-1:0]  remh_q  [QW+1];
  logic [RW-1:0]  remd_q  [QW+1];
  logic [QW-1:0]  rooth_q [QW+1];
  logic [QW-1:0]  rootd_q [QW+1];

  assign valid_q[0] = valid_i;
  assign vec_q[0]   = vec_i;
  assign remh_q[0]  = nh_i;
  assign remd_q[0]  = nd_i;
  assign rooth_q[0] = '0;
  assign rootd_q[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_bit
    localparam int unsigned B = QW - 1 - k;
    logic [RW-1:0] trh, trd;
    assign trh = (RW'(rooth_q[k]) << (B + 1)) | (RW'(1) << (2 * B));
    assign trd = (RW'(rootd_q[k]) << (B + 1)) | (RW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vec_q[k+1] <= vec_q[k];
        if (remh_q[k] >= trh) begin
          remh_q[k+1]  <= remh_q[k] - trh;
          rooth_q[k+1] <= rooth_q[k] | (QW'(1) << B);
        end else begin
          remh_q[k+1]  <= remh_q[k];
          rooth_q[k+1] <= rooth_q[k];
        end
        if (remd_q[k] >= trd) begin
          remd_q[k+1]  <= remd_q[k] - trd;
          rootd_q[k+1] <= rootd_q[k] | (QW'(1) << B);
        end else begin
          remd_q[k+1]  <= remd_q[k];
          rootd_q[k+1] <= rootd_q[k];
        end
      end
    end
  end

  assign valid_o = valid_q[QW];
  assign vec_o   = vec_q[QW];
  assign horiz_o = rooth_q[QW];
  assign dist_o  = rootd_q[QW];

endmodule

### hdl/vtpy_cordic.sv
module vtpy_cordic #(
  parameter int unsigned Steps = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  vtpy_pkg::vec_t                    vec_i,
  input  logic [vtpy_pkg::RootW-1:0]        horiz_i,
  input  logic [vtpy_pkg::RootW-1:0]        dist_i,
  output logic                              valid_o,
  output logic                              nz_o,
  output logic signed [vtpy_pkg::AngW-1:0]  zp_o,
  output logic signed [vtpy_pkg::AngW-1:0]  zy_o,
  output logic [vtpy_pkg::DistW-1:0]        dist_o
);

  localparam int unsigned XW = vtpy_pkg::CordW;
  localparam int unsigned DW = vtpy_pkg::DistW;

  logic                valid_q [Steps+1];
  logic                nz_q    [Steps+1];
  logic [DW-1:0]       dist_q  [Steps+1];
  vtpy_pkg::cordic_t   p_q     [Steps+1];
  vtpy_pkg::cordic_t   y_q     [Steps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nz_q[0]   <= vec_i.nz;
      dist_q[0] <= DW'(dist_i);
      p_q[0]    <= vtpy_pkg::cordic_init(XW'(vec_i.dz), XW'({1'b0, horiz_i}));
      y_q[0]    <= vtpy_pkg::cordic_init(XW'(vec_i.dy), XW'(vec_i.dx));
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam logic signed [vtpy_pkg::AngW-1:0] Ang = vtpy_pkg::AtanDeg[i];
    vtpy_pkg::cordic_t p_d, y_d;

    always_comb begin
      p_d = p_q[i];
      y_d = y_q[i];
      if (!p_q[i].y[XW-1]) begin
        p_d.x = p_q[i].x + (p_q[i].y >>> i);
        p_d.y = p_q[i].y - (p_q[i].x >>> i);
        p_d.z = p_q[i].z + Ang;
      end else begin
        p_d.x = p_q[i].x - (p_q[i].y >>> i);
        p_d.y = p_q[i].y + (p_q[i].x >>> i);
        p_d.z = p_q[i].z - Ang;
      end
      if (!y_q[i].y[XW-1]) begin
        y_d.x = y_q[i].x + (y_q[i].y >>> i);
        y_d.y = y_q[i].y - (y_q[i].x >>> i);
        y_d.z = y_q[i].z + Ang;
      end else begin
        y_d.x = y_q[i].x - (y_q[i].y >>> i);
        y_d.y = y_q[i].y + (y_q[i].x >>> i);
        y_d.z = y_q[i].z - Ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nz_q[i+1]   <= nz_q[i];
        dist_q[i+1] <= dist_q[i];
        p_q[i+1]    <= p_d;
        y_q[i+1]    <= y_d;
      end
    end
  end

  assign valid_o = valid_q[Steps];
  assign nz_o    = nz_q[Steps];
  assign zp_o    = p_q[Steps].z;
  assign zy_o    = y_q[Steps].z;
  assign dist_o  = dist_q[Steps];

endmodule

### hdl/vector_to_pitch_yaw.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: src_x,src_y,src_z,dst_x,dst_y,dst_z
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: pitch,yaw,distance; tuser: angles_valid
//
// One item is accepted per cycle while the output is not stalled.
// The pipeline holds three front stages, the 34 one-bit square root stages,
// one setup and CORDIC_STEPS rotation stages, and the output register.
// Reset clears every valid bit; the data registers are not reset.
// A stall on the output freezes the whole pipeline, so nothing is lost or repeated.
module vector_to_pitch_yaw #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // src_x[31:0], src_y[63:32], src_z[95:64], dst_x[127:96], dst_y[159:128], dst_z[191:160]
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pitch[23:0], yaw[48:24], distance[81:49], zero[87:82]
  output logic [87:0]  m_axis_tdata,
  // angles_valid[0]
  output logic         m_axis_tuser
);

  localparam int unsigned AW = vtpy_pkg::AngW;

  logic en;
  logic f_valid, s_valid, c_valid, c_nz;
  vtpy_pkg::vec_t f_vec, s_vec;
  logic [vtpy_pkg::RadW-1:0]  f_nh, f_nd;
  logic [vtpy_pkg::RootW-1:0] s_horiz, s_dist;
  logic signed [AW-1:0] c_zp, c_zy, pitch_d, yaw_d;
  logic [vtpy_pkg::DistW-1:0] c_dist, dist_q;
  logic ok_d, valid_q, ok_q;
  logic [vtpy_pkg::PitchW-1:0] pitch_q;
  logic [vtpy_pkg::YawW-1:0]   yaw_q;

  assign en            = !valid_q || m_axis_tready;
  assign s_axis_tready = en;

  vtpy_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_axis_tvalid), .data_i(s_axis_tdata),
    .valid_o(f_valid), .vec_o(f_vec), .nh_o(f_nh), .nd_o(f_nd)
  );

  vtpy_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(f_valid), .vec_i(f_vec), .nh_i(f_nh), .nd_i(f_nd),
    .valid_o(s_valid), .vec_o(s_vec), .horiz_o(s_horiz), .dist_o(s_dist)
  );

  vtpy_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_valid), .vec_i(s_vec), .horiz_i(s_horiz), .dist_i(s_dist),
    .valid_o(c_valid), .nz_o(c_nz), .zp_o(c_zp), .zy_o(c_zy), .dist_o(c_dist)
  );

  always_comb begin
    pitch_d = -c_zp;
    yaw_d   = c_zy;
    if (yaw_d > vtpy_pkg::HalfTurn) begin
      yaw_d = vtpy_pkg::HalfTurn;
    end
    if (yaw_d < -vtpy_pkg::HalfTurn) begin
      yaw_d = -vtpy_pkg::HalfTurn;
    end
    ok_d = c_nz && (pitch_d <= vtpy_pkg::PitchLimit) && (pitch_d >= -vtpy_pkg::PitchLimit);
    if (!ok_d) begin
      pitch_d = '0;
      yaw_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pitch_q <= pitch_d[vtpy_pkg::PitchW-1:0];
      yaw_q   <= yaw_d[vtpy_pkg::YawW-1:0];
      ok_q    <= ok_d;
      dist_q  <= c_dist;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {6'b0, dist_q, yaw_q, pitch_q};
  assign m_axis_tuser  = ok_q;

  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output stall");

  a_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (pitch_q == '0 && yaw_q == '0))
    else $error("angles not cleared on an invalid item");

  a_dist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (dist_q != '0))
    else $error("valid angles with zero distance");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(dist_q) && $stable(ok_q)))
    else $error("stalled result changed");

endmodule

### verif/tb_vector_to_pitch_yaw.sv
`timescale 1ns / 1ps

module tb_vector_to_pitch_yaw;

  localparam int unsigned Steps = 20;
  localparam int unsigned Latency = 40 + Steps;
  localparam int unsigned RandItems = 700;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic [23:0] pitch;
    logic [24:0] yaw;
    logic        ok;
    logic [32:0] span;
  } aim_t;

  int errors = 0;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // Floor of the square root of a value below 2^68.
  function automatic logic [33:0] root_floor(input logic [67:0] n);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if ({34'd0, c} * {34'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] angle_of(input logic signed [63:0] y0,
                                                  input logic signed [63:0] x0);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    x = x0;
    y = y0;
    z = 0;
    if (x < 0) begin
      z = (y < 0) ? -64'sd11796480 : 64'sd11796480;
      x = -x;
      y = -y;
    end
    x = x <<< 16;
    y = y <<< 16;
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + $signed({32'd0, vtpy_pkg::AtanDeg[i]});
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - $signed({32'd0, vtpy_pkg::AtanDeg[i]});
      end
    end
    return z;
  endfunction

  function automatic aim_t aim_from(input logic [191:0] d);
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [63:0] dz;
    logic [67:0] hsq;
    logic [67:0] tsq;
    logic [33:0] full_len;
    logic signed [63:0] pitch;
    logic signed [63:0] yaw;
    logic ok;
    aim_t r;
    dx = 64'($signed(d[127:96])) - 64'($signed(d[31:0]));
    dy = 64'($signed(d[159:128])) - 64'($signed(d[63:32]));
    dz = 64'($signed(d[191:160])) - 64'($signed(d[95:64]));
    hsq = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy);
    tsq = hsq + 68'(dz) * 68'(dz);
    pitch = -angle_of(dz, 64'(root_floor(hsq)));
    yaw = angle_of(dy, dx);
    if (yaw > 64'sd11796480) yaw = 64'sd11796480;
    if (yaw < -64'sd11796480) yaw = -64'sd11796480;
    ok = (tsq != 0) && pitch <= 64'sd5832704 && pitch >= -64'sd5832704;
    if (!ok) begin
      pitch = 0;
      yaw = 0;
    end
    full_len = root_floor(tsq);
    r.pitch = pitch[23:0];
    r.yaw = yaw[24:0];
    r.ok = ok;
    r.span = full_len[32:0];
    return r;
  endfunction

  class aim_board;
    aim_t pending[$];

    function void note_pair(input logic [191:0] d);
      pending = {pending, aim_from(d)};
    endfunction

    task check_aim(input logic [87:0] data, input logic user);
      aim_t e;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (data[23:0] != e.pitch)
        report($sformatf("pitch %h, expected %h", data[23:0], e.pitch));
      if (data[48:24] != e.yaw)
        report($sformatf("yaw %h, expected %h", data[48:24], e.yaw));
      if (data[81:49] != e.span)
        report($sformatf("distance %h, expected %h", data[81:49], e.span));
      if (data[87:82] != '0) report("padding bits not zero");
      if (user != e.ok) report($sformatf("angles_valid %b, expected %b", user, e.ok));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic m_axis_tuser;

  aim_board board = new();
  logic calm = 1'b0;
  longint cycles = 0;

  vector_to_pitch_yaw #(.CORDIC_STEPS(Steps)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_vector_to_pitch_yaw failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_aim(m_axis_tdata, m_axis_tuser);
  end

  // Receiver stalls come in bursts.
  initial begin
    int n;
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_pair(input logic [191:0] d);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_pair(d);
  endtask

  function automatic logic [31:0] coord(input int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [191:0] pair_rand();
    logic [31:0] s [3];
    logic [31:0] e [3];
    int kind;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      s[i] = coord(kind == 3 ? $urandom_range(0, 3) : kind);
      e[i] = coord(kind == 3 ? $urandom_range(0, 3) : kind);
    end
    // Occasionally make a flat or vertical difference, or zero one horizontal component.
    case ($urandom_range(0, 9))
      0: e[2] = s[2];
      1: begin
        e[0] = s[0];
        e[1] = s[1];
      end
      2: e[0] = s[0];
      3: e[1] = s[1];
      default: ;
    endcase
    return {e[2], e[1], e[0], s[2], s[1], s[0]};
  endfunction

  initial begin
    logic [31:0] mn;
    logic [31:0] mx;
    logic [31:0] u;
    mn = 32'h8000_0000;
    mx = 32'h7FFF_FFFF;
    u = 32'h0001_0000;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_pair('0);
    send_pair({u, u, u, u, u, u});
    send_pair({32'd0, 32'd0, u, 96'd0});
    send_pair({32'd0, 32'd0, -u, 96'd0});
    send_pair({32'd0, u, 32'd0, 96'd0});
    send_pair({32'd0, -u, 32'd0, 96'd0});
    send_pair({32'd0, 32'd0, -u, 96'd0});
    send_pair({32'd0, 32'd1, -u, 96'd0});
    send_pair({32'd0, -32'sd1, -u, 96'd0});
    send_pair({u, 32'd0, 32'd0, 96'd0});
    send_pair({-u, 32'd0, 32'd0, 96'd0});
    send_pair({32'd0 + 32'd100, 32'd0, 32'd1, 96'd0});
    send_pair({mx, mx, mx, mn, mn, mn});
    send_pair({mn, mn, mn, mx, mx, mx});
    send_pair({mx, mn, mx, mn, mx, mn});
    send_pair({mn, mx, mn, 32'd0, 32'd0, 32'd0});
    send_pair({u, u, u, 96'd0});
    send_pair({-u, -u, u, 96'd0});
    send_pair({32'h0000_8000, u, u, 96'd0});
    send_pair({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 96'd0});
    for (int k = 0; k < RandItems; k++) begin
      if (k == RandItems - 100) calm = 1'b1;
      send_pair(pair_rand());
    end
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_vector_to_pitch_yaw passed");
    end else begin
      $display("tb_vector_to_pitch_yaw failed");
    end
    $finish;
  end

endmodule
